[rtl/eqsf_pkg.sv]
// ----------------------------------------------------------------------------
// eqsf_pkg: shared types and constants of the quarter-ellipse span generator
//
// Field widths, internal arithmetic widths, corner code bits and the
// structs that travel between the controller, datapath and span buffer.
// ----------------------------------------------------------------------------
package eqsf_pkg;

  // Fixed field widths of the request and span items.
  localparam int COORD_W = 16;
  localparam int RAD_W   = 6;

  // Internal widths, sized for radii up to 45.
  localparam int STEP_W  = 7;   // x and y step counters
  localparam int SQ_W    = 11;  // squared radius
  localparam int PROD_W  = 18;  // squared radius times a step
  localparam int DEC_W   = 24;  // signed decision value
  localparam int CNT_W   = 7;   // spans issued, up to the span limit

  // Span limit per request.
  localparam int MAX_SPANS  = 64;
  // Radii below this draw nothing.
  localparam int MIN_RADIUS = 2;

  // Corner code bits: bit 0 set means a right corner, bit 1 a bottom corner.
  localparam int CORNER_RIGHT_BIT  = 0;
  localparam int CORNER_BOTTOM_BIT = 1;

  // One request item.
  typedef struct packed {
    logic [1:0]                corner;
    logic signed [COORD_W-1:0] anchor_x;
    logic signed [COORD_W-1:0] anchor_y;
    logic [RAD_W-1:0]          radius_x;
    logic [RAD_W-1:0]          radius_y;
    logic                      fill_index;
  } req_t;

  // One span, without its last marker.
  typedef struct packed {
    logic signed [COORD_W-1:0] span_x;
    logic signed [COORD_W-1:0] span_y;
    logic [RAD_W-1:0]          span_len;
    logic                      span_fill;
  } span_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new request
    logic square;   // square both radii
    logic init1;    // set up region one
    logic init2;    // set up region two
    logic step;     // one recurrence step
    logic region2;  // the step belongs to region two
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic small_rad;  // a radius is below the minimum
    logic cont1;      // region one loop condition holds
    logic cont2;      // region two loop condition holds
    logic cap;        // span limit reached
  } dp_stat_t;

  // Status from the span buffer to the controller.
  typedef struct packed {
    logic hold_v;      // a span waits in the hold stage
    logic can_push;    // a new span may enter this cycle
    logic can_finish;  // the held span may move out this cycle
  } buf_stat_t;

endpackage

[rtl/eqsf_if.sv]
// ----------------------------------------------------------------------------
// eqsf_if: request and span channels
//
// Valid/ready channels; an item moves at a clock edge where both are high.
// ----------------------------------------------------------------------------
interface eqsf_req_if import eqsf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                corner;
  logic signed [COORD_W-1:0] anchor_x;
  logic signed [COORD_W-1:0] anchor_y;
  logic [RAD_W-1:0]          radius_x;
  logic [RAD_W-1:0]          radius_y;
  logic                      fill_index;

  modport source (
    output valid, corner, anchor_x, anchor_y, radius_x, radius_y, fill_index,
    input  ready
  );
  modport sink (
    input  valid, corner, anchor_x, anchor_y, radius_x, radius_y, fill_index,
    output ready
  );
endinterface

interface eqsf_span_if import eqsf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] span_x;
  logic signed [COORD_W-1:0] span_y;
  logic [RAD_W-1:0]          span_len;
  logic                      span_fill;
  logic                      last_span;

  modport source (
    output valid, span_x, span_y, span_len, span_fill, last_span,
    input  ready
  );
  modport sink (
    input  valid, span_x, span_y, span_len, span_fill, last_span,
    output ready
  );
endinterface

[rtl/eqsf_dp.sv]
// ----------------------------------------------------------------------------
// eqsf_dp: midpoint ellipse datapath
//
// Holds the request, the squared radii, the x/y steps, their running
// products with the squared radii and the decision value. The products are
// kept incrementally so that a step needs adds only.
// ----------------------------------------------------------------------------
module eqsf_dp import eqsf_pkg::*; #(
  parameter int MAX_RADIUS = 40
) (
  input  logic     clk,
  input  logic     rst_n,
  input  req_t     req,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     push,
  output span_t    push_span
);

  logic [RAD_W-1:0]          rx_r, ry_r;
  logic [SQ_W-1:0]           rx2_r, ry2_r;
  logic [STEP_W-1:0]         x_r, y_r;
  logic [PROD_W-1:0]         px_r, py_r;
  logic signed [DEC_W-1:0]   s_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic                      right_r, bottom_r, fill_r;

  logic [RAD_W-1:0]          rx_sat, ry_sat;
  logic [SQ_W-1:0]           rx_sq, ry_sq;
  logic [PROD_W-1:0]         mul_a, mul_b, mul_p;
  logic signed [DEC_W-1:0]   e_rx2, e_ry2, e_px, e_py, e_mul, s_init, s_step, s_adj;
  logic                      s_pos;
  logic [COORD_W-1:0]        x_ext, y_ext;

  // Saturate the radii to the supported maximum.
  always_comb begin
    rx_sat = (req.radius_x > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : req.radius_x;
    ry_sat = (req.radius_y > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : req.radius_y;
  end

  // Held radii widened to the squared-radius width.
  always_comb begin
    rx_sq = SQ_W'(rx_r);
    ry_sq = SQ_W'(ry_r);
  end

  // Shared multiplier for the region start products.
  always_comb begin
    mul_a = cmd.init1 ? PROD_W'(rx2_r) : PROD_W'(ry2_r);
    mul_b = cmd.init1 ? PROD_W'(ry_r)  : PROD_W'(rx_r);
    mul_p = mul_a * mul_b;
  end

  // Signed views of the unsigned terms.
  always_comb begin
    e_rx2 = signed'(DEC_W'(rx2_r));
    e_ry2 = signed'(DEC_W'(ry2_r));
    e_px  = signed'(DEC_W'(px_r));
    e_py  = signed'(DEC_W'(py_r));
    e_mul = signed'(DEC_W'(mul_p));
    s_pos = ~s_r[DEC_W-1];
  end

  // Region start decision: 2*b2 + a2 - 2*a2*r, with the roles of the axes
  // swapped in region two.
  always_comb begin
    if (cmd.init1) begin
      s_init = (e_ry2 <<< 1) + e_rx2 - (e_mul <<< 1);
    end else begin
      s_init = (e_rx2 <<< 1) + e_ry2 - (e_mul <<< 1);
    end
  end

  // Decision update of one step. The terms 4*a2*(1-v) and b2*(4*u+6) are
  // formed from the running products of the old steps.
  always_comb begin
    if (cmd.region2) begin
      s_adj  = s_pos ? ((e_ry2 <<< 2) - (e_px <<< 2)) : '0;
      s_step = s_r + s_adj + (e_py <<< 2) + (e_rx2 <<< 2) + (e_rx2 <<< 1);
    end else begin
      s_adj  = s_pos ? ((e_rx2 <<< 2) - (e_py <<< 2)) : '0;
      s_step = s_r + s_adj + (e_px <<< 2) + (e_ry2 <<< 2) + (e_ry2 <<< 1);
    end
  end

  // Request and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx_r     <= rx_sat;
      ry_r     <= ry_sat;
      cx_r     <= req.anchor_x;
      cy_r     <= req.anchor_y;
      right_r  <= req.corner[CORNER_RIGHT_BIT];
      bottom_r <= req.corner[CORNER_BOTTOM_BIT];
      fill_r   <= req.fill_index;
    end
    if (cmd.square) begin
      rx2_r <= rx_sq * rx_sq;
      ry2_r <= ry_sq * ry_sq;
    end
    if (cmd.init1) begin
      x_r  <= '0;
      y_r  <= STEP_W'(ry_r);
      px_r <= '0;
      py_r <= mul_p;
      s_r  <= s_init;
    end else if (cmd.init2) begin
      x_r  <= STEP_W'(rx_r);
      y_r  <= '0;
      px_r <= mul_p;
      py_r <= '0;
      s_r  <= s_init;
    end else if (cmd.step) begin
      s_r <= s_step;
      if (cmd.region2) begin
        y_r  <= y_r + 1'b1;
        py_r <= py_r + PROD_W'(rx2_r);
        if (s_pos) begin
          x_r  <= x_r - 1'b1;
          px_r <= px_r - PROD_W'(ry2_r);
        end
      end else begin
        x_r  <= x_r + 1'b1;
        px_r <= px_r + PROD_W'(ry2_r);
        if (s_pos) begin
          y_r  <= y_r - 1'b1;
          py_r <= py_r - PROD_W'(rx2_r);
        end
      end
    end
  end

  // Span count of the current request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Span of the current step; a span of length zero is dropped.
  always_comb begin
    x_ext = COORD_W'(x_r);
    y_ext = COORD_W'(y_r);
    push  = cmd.step && (x_r != '0);
    push_span.span_x    = right_r ? cx_r : signed'(cx_r - x_ext);
    push_span.span_y    = bottom_r ? signed'(cy_r + y_ext - 1'b1) : signed'(cy_r - y_ext);
    push_span.span_len  = x_r[RAD_W-1:0];
    push_span.span_fill = fill_r;
  end

  // Status for the controller.
  always_comb begin
    stat.small_rad = (rx_r < RAD_W'(MIN_RADIUS)) || (ry_r < RAD_W'(MIN_RADIUS));
    stat.cont1     = px_r <= py_r;
    stat.cont2     = py_r <= px_r;
    stat.cap       = cnt_r == CNT_W'(MAX_SPANS);
  end

endmodule

[rtl/eqsf_span_buf.sv]
// ----------------------------------------------------------------------------
// eqsf_span_buf: span hold stage and output register
//
// A span waits in the hold stage until the next one arrives or the walk
// ends, so the final span of a request can be marked last. The output
// register parts the walk from the consumer.
// ----------------------------------------------------------------------------
module eqsf_span_buf import eqsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  span_t     push_span,
  input  logic      finish,
  output buf_stat_t stat,
  eqsf_span_if.source out_span
);

  span_t hold_r, out_r;
  logic  hold_v_r, hold_v_nxt;
  logic  out_v_r, out_v_nxt;
  logic  out_last_r;
  logic  move;

  // A held span moves out when a newer one replaces it or the walk ends.
  assign move = (push && hold_v_r) || finish;

  // Valid flags of both stages.
  always_comb begin
    out_v_nxt  = out_v_r && !out_span.ready;
    hold_v_nxt = hold_v_r;
    if (push) begin
      hold_v_nxt = 1'b1;
    end
    if (finish) begin
      hold_v_nxt = 1'b0;
    end
    if (move) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Span payloads.
  always_ff @(posedge clk) begin
    if (push) begin
      hold_r <= push_span;
    end
    if (move) begin
      out_r      <= hold_r;
      out_last_r <= finish;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.hold_v     = hold_v_r;
    stat.can_push   = !(hold_v_r && out_v_r && !out_span.ready);
    stat.can_finish = !out_v_r || out_span.ready;
  end

  assign out_span.valid     = out_v_r;
  assign out_span.span_x    = out_r.span_x;
  assign out_span.span_y    = out_r.span_y;
  assign out_span.span_len  = out_r.span_len;
  assign out_span.span_fill = out_r.span_fill;
  assign out_span.last_span = out_last_r;

  // A span never enters while the held one has nowhere to go.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> stat.can_push)
    else $error("span pushed while both stages are full");

  // The walk ends only with a span held and no new span arriving.
  a_finish_held: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (hold_v_r && !push && stat.can_finish))
    else $error("finish without a movable held span");

endmodule

[rtl/eqsf_ctrl.sv]
// ----------------------------------------------------------------------------
// eqsf_ctrl: walk controller
//
// Sequences setup, region one, region two and the final flush of a request,
// and stalls the walk while the span buffer is full.
// ----------------------------------------------------------------------------
module eqsf_ctrl import eqsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  dp_stat,
  input  buf_stat_t buf_stat,
  output dp_cmd_t   cmd,
  output logic      finish
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SQUARE = 7'b0000010,
    S_INIT1  = 7'b0000100,
    S_WALK1  = 7'b0001000,
    S_INIT2  = 7'b0010000,
    S_WALK2  = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    finish    = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = dp_stat.small_rad ? S_IDLE : S_INIT1;
      end
      S_INIT1: begin
        cmd.init1 = 1'b1;
        state_nxt = S_WALK1;
      end
      S_WALK1: begin
        if (dp_stat.cap) begin
          state_nxt = S_FLUSH;
        end else if (!dp_stat.cont1) begin
          state_nxt = S_INIT2;
        end else begin
          cmd.step = buf_stat.can_push;
        end
      end
      S_INIT2: begin
        cmd.init2 = 1'b1;
        state_nxt = S_WALK2;
      end
      S_WALK2: begin
        cmd.region2 = 1'b1;
        if (dp_stat.cap || !dp_stat.cont2) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.step = buf_stat.can_push;
        end
      end
      S_FLUSH: begin
        // Mark the held span last once the output register can take it.
        if (!buf_stat.hold_v) begin
          state_nxt = S_IDLE;
        end else if (buf_stat.can_finish) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted request always starts with the squaring cycle.
  a_accept_square: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SQUARE))
    else $error("accepted request did not start setup");

  // Recurrence steps happen only while walking a region.
  a_step_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> ((state_r == S_WALK1) || (state_r == S_WALK2)))
    else $error("step issued outside a walk");

endmodule

[rtl/ellipse_quadrant_span_fill.sv]
// ----------------------------------------------------------------------------
// ellipse_quadrant_span_fill: quarter-ellipse horizontal span generator
//
// A request selects a corner, an anchor point, two radii and a fill index.
// The block walks the two-region integer midpoint ellipse recurrence and
// returns one span per step of nonzero length, the final one marked last.
//
// A request is taken in the idle state; the block then squares the radii,
// sets up region one, walks the recurrence steps of region one until it sees
// that region end, sets up region two, walks the steps of region two until
// it sees that region end, and releases the final span. The two regions
// together take about sqrt(rx^2 + ry^2) + 2 recurrence steps. A single step
// unit updates the decision value once per cycle while no step waits. A step
// waits while both span stages are full, and the release waits until the
// output register is free. Radii above MAX_RADIUS are clamped; a radius below
// 2 returns no span, and the controller goes from the squaring state straight
// back to idle, where the next request can be taken. A new request is taken
// once the previous walk has ended, while its last span may still wait in
// the output register. At most 64 spans are returned per request.
// ----------------------------------------------------------------------------
module ellipse_quadrant_span_fill import eqsf_pkg::*; #(
  parameter int MAX_RADIUS = 40
) (
  input  logic clk,
  input  logic rst_n,
  eqsf_req_if.sink    in_req,
  eqsf_span_if.source out_span
);

  req_t      req;
  dp_cmd_t   cmd;
  dp_stat_t  dp_stat;
  buf_stat_t buf_stat;
  logic      in_ready;
  logic      finish;
  logic      push;
  span_t     push_span;

  // Gather the request fields.
  always_comb begin
    req.corner     = in_req.corner;
    req.anchor_x   = in_req.anchor_x;
    req.anchor_y   = in_req.anchor_y;
    req.radius_x   = in_req.radius_x;
    req.radius_y   = in_req.radius_y;
    req.fill_index = in_req.fill_index;
  end

  assign in_req.ready = in_ready;

  eqsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .dp_stat  (dp_stat),
    .buf_stat (buf_stat),
    .cmd      (cmd),
    .finish   (finish)
  );

  eqsf_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .cmd       (cmd),
    .stat      (dp_stat),
    .push      (push),
    .push_span (push_span)
  );

  eqsf_span_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_span (push_span),
    .finish    (finish),
    .stat      (buf_stat),
    .out_span  (out_span)
  );

endmodule

[dv/ellipse_quadrant_span_fill_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ellipse_quadrant_span_fill_tb: span-level check of the quarter-ellipse
// span generator
//
// A directed list covers every corner, both fill values, clamped and too
// small radii and coordinate wrap. A random mix follows. Each accepted
// request is walked by a local midpoint ellipse model, and the spans it
// yields are queued in order. Every span the block returns is compared,
// field by field, with the oldest queued span. Both channels idle at random.
// ----------------------------------------------------------------------------
module ellipse_quadrant_span_fill_tb;
  import eqsf_pkg::*;

  localparam int RADIUS_LIMIT = 40;
  localparam int LOOP_GUARD   = 4 * RADIUS_LIMIT + 8;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;

  // Corner codes of the request.
  localparam logic [1:0] CORNER_TOP_LEFT     = 2'd0;
  localparam logic [1:0] CORNER_TOP_RIGHT    = 2'd1;
  localparam logic [1:0] CORNER_BOTTOM_LEFT  = 2'd2;
  localparam logic [1:0] CORNER_BOTTOM_RIGHT = 2'd3;

  // One predicted span with its last marker.
  typedef struct packed {
    span_t span;
    logic  last_span;
  } span_due_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  eqsf_req_if  in_req ();
  eqsf_span_if out_span ();

  ellipse_quadrant_span_fill #(
    .MAX_RADIUS (RADIUS_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_span (out_span)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t      pending_req[$];
  span_due_t span_due[$];
  span_due_t quadrant_spans[$];
  int        request_total;
  int        accepted_cnt;
  int        error_count;
  int        in_gap;
  int        out_stall;
  bit        in_calm;
  bit        out_calm;
  logic      in_fire;
  logic      out_fire;

  // Adds one span of the current walk, skipping empty spans and those past
  // the span limit.
  function automatic void add_span(int sx, int sy, int len, logic fill);
    span_due_t s;
    if (len <= 0 || quadrant_spans.size() >= MAX_SPANS) return;
    s.span.span_x    = 16'(sx);
    s.span.span_y    = 16'(sy);
    s.span.span_len  = 6'(len);
    s.span.span_fill = fill;
    s.last_span      = 1'b0;
    quadrant_spans.push_back(s);
  endfunction

  // Walks both regions of the midpoint ellipse recurrence for one request
  // and queues the spans it yields.
  function automatic void plan_spans(req_t r);
    int rx, ry, rx2, ry2, x, y, d, cx, cy, guard;
    bit left, bottom;
    rx = (r.radius_x > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(r.radius_x);
    ry = (r.radius_y > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(r.radius_y);
    if (rx < MIN_RADIUS || ry < MIN_RADIUS) return;
    left   = !r.corner[CORNER_RIGHT_BIT];
    bottom = r.corner[CORNER_BOTTOM_BIT];
    cx     = int'($signed(r.anchor_x));
    cy     = int'($signed(r.anchor_y));
    rx2    = rx * rx;
    ry2    = ry * ry;
    quadrant_spans.delete();

    // Region one: flat part, stepping x.
    x = 0;
    y = ry;
    d = 2 * ry2 + rx2 * (1 - 2 * ry);
    for (guard = 0; guard < LOOP_GUARD && ry2 * x <= rx2 * y; guard++) begin
      add_span(left ? cx - x : cx, bottom ? cy + y - 1 : cy - y, x, r.fill_index);
      if (d >= 0) begin
        d += 4 * rx2 * (1 - y);
        y--;
      end
      d += ry2 * (4 * x + 6);
      x++;
    end

    // Region two: steep part, stepping y.
    x = rx;
    y = 0;
    d = 2 * rx2 + ry2 * (1 - 2 * rx);
    for (guard = 0; guard < LOOP_GUARD && rx2 * y <= ry2 * x; guard++) begin
      add_span(left ? cx - x : cx, bottom ? cy + y - 1 : cy - y, x, r.fill_index);
      if (d >= 0) begin
        d += 4 * ry2 * (1 - x);
        x--;
      end
      d += rx2 * (4 * y + 6);
      y++;
    end

    if (quadrant_spans.size() != 0) begin
      quadrant_spans[quadrant_spans.size() - 1].last_span = 1'b1;
    end
    foreach (quadrant_spans[i]) span_due.push_back(quadrant_spans[i]);
  endfunction

  function automatic req_t make_req(logic [1:0] corner, int cx, int cy, int rx, int ry,
                                    logic fill);
    req_t r;
    r.corner     = corner;
    r.anchor_x   = 16'(cx);
    r.anchor_y   = 16'(cy);
    r.radius_x   = 6'(rx);
    r.radius_y   = 6'(ry);
    r.fill_index = fill;
    return r;
  endfunction

  // Mostly drawable radii, small ones most often, with some too small and
  // some above the clamp.
  function automatic int pick_radius();
    int p;
    p = $urandom_range(0, 99);
    if (p < 6) return $urandom_range(0, 1);
    if (p < 14) return $urandom_range(RADIUS_LIMIT + 1, 63);
    if (p < 70) return $urandom_range(2, 16);
    return $urandom_range(2, RADIUS_LIMIT);
  endfunction

  // Anchor coordinates anywhere, or close to an end of the range so that
  // spans wrap.
  function automatic int pick_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return $urandom_range(0, 16'hFFFF);
    if (p < 8) return 16'h8000 + $urandom_range(0, 50);
    if (p < 9) return 16'h7FFF - $urandom_range(0, 50);
    return $urandom_range(0, 100) - 50;
  endfunction

  // Wait before the next item, with occasional stretches of no waiting.
  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // Request driver: presents one queued item, holds it until taken, then
  // idles for the drawn gap.
  always @(negedge clk) begin
    req_t nxt;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (in_req.valid && !in_fire) begin
      in_req.valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_req.valid <= 1'b0;
      in_gap       <= in_gap - 1;
    end else if (pending_req.size() != 0) begin
      nxt = pending_req.pop_front();
      in_req.corner     <= nxt.corner;
      in_req.anchor_x   <= nxt.anchor_x;
      in_req.anchor_y   <= nxt.anchor_y;
      in_req.radius_x   <= nxt.radius_x;
      in_req.radius_y   <= nxt.radius_y;
      in_req.fill_index <= nxt.fill_index;
      in_req.valid      <= 1'b1;
      if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
      in_gap <= draw_wait(in_calm);
    end else begin
      in_req.valid <= 1'b0;
    end
  end

  // Span sink: stalls for a drawn number of cycles after each item taken.
  always @(negedge clk) begin
    int stall;
    if (!rst_n) begin
      out_span.ready <= 1'b0;
    end else begin
      stall = out_stall;
      if (out_fire) begin
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
        stall = draw_wait(out_calm);
      end
      if (stall > 0) begin
        out_span.ready <= 1'b0;
        out_stall      <= stall - 1;
      end else begin
        out_span.ready <= 1'b1;
        out_stall      <= 0;
      end
    end
  end

  // Monitor: predicts spans of every accepted request and checks every
  // returned span against the oldest prediction.
  always @(posedge clk) begin
    req_t      r;
    span_due_t due;
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_req.valid && in_req.ready;
      out_fire <= out_span.valid && out_span.ready;
      if (in_req.valid && in_req.ready) begin
        r.corner     = in_req.corner;
        r.anchor_x   = in_req.anchor_x;
        r.anchor_y   = in_req.anchor_y;
        r.radius_x   = in_req.radius_x;
        r.radius_y   = in_req.radius_y;
        r.fill_index = in_req.fill_index;
        plan_spans(r);
        accepted_cnt++;
      end
      if (out_span.valid && out_span.ready) begin
        if (span_due.size() == 0) begin
          report_error($sformatf("unexpected span x=%0d y=%0d len=%0d fill=%0b last=%0b",
                                 out_span.span_x, out_span.span_y, out_span.span_len,
                                 out_span.span_fill, out_span.last_span));
        end else begin
          due = span_due.pop_front();
          if (out_span.span_x !== due.span.span_x || out_span.span_y !== due.span.span_y ||
              out_span.span_len !== due.span.span_len ||
              out_span.span_fill !== due.span.span_fill ||
              out_span.last_span !== due.last_span) begin
            report_error($sformatf(
              "span mismatch: expected x=%0d y=%0d len=%0d fill=%0b last=%0b, got x=%0d y=%0d len=%0d fill=%0b last=%0b",
              due.span.span_x, due.span.span_y, due.span.span_len, due.span.span_fill,
              due.last_span, out_span.span_x, out_span.span_y, out_span.span_len,
              out_span.span_fill, out_span.last_span));
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    in_req.valid      = 1'b0;
    in_req.corner     = CORNER_TOP_LEFT;
    in_req.anchor_x   = '0;
    in_req.anchor_y   = '0;
    in_req.radius_x   = '0;
    in_req.radius_y   = '0;
    in_req.fill_index = 1'b0;
    out_span.ready    = 1'b0;
    in_fire           = 1'b0;
    out_fire          = 1'b0;
    accepted_cnt      = 0;
    error_count       = 0;
    in_gap            = 0;
    out_stall         = 0;
    in_calm           = 1'b0;
    out_calm          = 1'b0;

    // Every corner at full radius with both fill values.
    pending_req.push_back(make_req(CORNER_TOP_LEFT, 100, 100, 40, 40, 1'b0));
    pending_req.push_back(make_req(CORNER_TOP_RIGHT, 100, 100, 40, 40, 1'b1));
    pending_req.push_back(make_req(CORNER_BOTTOM_LEFT, -100, -100, 40, 40, 1'b1));
    pending_req.push_back(make_req(CORNER_BOTTOM_RIGHT, 0, 0, 40, 40, 1'b0));
    // Smallest drawable radii and very uneven shapes.
    pending_req.push_back(make_req(CORNER_TOP_LEFT, 5, 5, 2, 2, 1'b1));
    pending_req.push_back(make_req(CORNER_BOTTOM_RIGHT, 5, 5, 2, 40, 1'b0));
    pending_req.push_back(make_req(CORNER_TOP_RIGHT, 5, 5, 40, 2, 1'b1));
    // Radii too small to draw.
    pending_req.push_back(make_req(CORNER_TOP_LEFT, 1, 1, 0, 20, 1'b1));
    pending_req.push_back(make_req(CORNER_TOP_RIGHT, 1, 1, 20, 1, 1'b0));
    pending_req.push_back(make_req(CORNER_BOTTOM_LEFT, 1, 1, 1, 1, 1'b1));
    pending_req.push_back(make_req(CORNER_BOTTOM_RIGHT, 1, 1, 0, 0, 1'b0));
    // Radii above the clamp.
    pending_req.push_back(make_req(CORNER_BOTTOM_LEFT, 0, 0, 63, 63, 1'b1));
    pending_req.push_back(make_req(CORNER_TOP_RIGHT, 0, 0, 41, 10, 1'b0));
    pending_req.push_back(make_req(CORNER_BOTTOM_RIGHT, 0, 0, 10, 62, 1'b1));
    // Anchors at the ends of the coordinate range, spans wrap.
    pending_req.push_back(make_req(CORNER_TOP_LEFT, -32768, -32768, 40, 40, 1'b1));
    pending_req.push_back(make_req(CORNER_BOTTOM_RIGHT, 32767, 32767, 40, 40, 1'b0));
    pending_req.push_back(make_req(CORNER_BOTTOM_LEFT, -32768, 32767, 30, 30, 1'b1));
    pending_req.push_back(make_req(CORNER_TOP_RIGHT, 32767, -32768, 30, 30, 1'b0));
    pending_req.push_back(make_req(CORNER_TOP_LEFT, -32767, 32766, 3, 7, 1'b0));

    // Random requests.
    repeat (RANDOM_ITEMS) begin
      pending_req.push_back(make_req(2'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                                     pick_radius(), pick_radius(), 1'($urandom_range(0, 1))));
    end
    request_total = pending_req.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < request_total) @(negedge clk);
    while (span_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[ellipse_quadrant_span_fill.f]
rtl/eqsf_pkg.sv
rtl/eqsf_if.sv
rtl/eqsf_dp.sv
rtl/eqsf_span_buf.sv
rtl/eqsf_ctrl.sv
rtl/ellipse_quadrant_span_fill.sv
dv/ellipse_quadrant_span_fill_tb.sv
